@@ design/clp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    // Coordinate format: signed fixed point, COORD_BITS in total.
    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 4;

    // Product of two differences and the width of the signed sum.
    localparam int PROD_BITS     = 2 * COORD_BITS;
    localparam int SUM_BITS      = PROD_BITS + 2;
    localparam int DIV_CNT_BITS  = $clog2(PROD_BITS + 1);

    localparam int CLIP_PASS_LIMIT = 8;
    localparam int PASS_BITS       = $clog2(CLIP_PASS_LIMIT + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [COORD_BITS:0]   t_diff;
    typedef logic        [COORD_BITS-1:0] t_mag;
    typedef logic        [PROD_BITS-1:0]  t_prod;
    typedef logic signed [SUM_BITS-1:0]   t_sum;
    typedef logic        [3:0]            t_code;

    localparam t_code CODE_LEFT   = 4'b0001;
    localparam t_code CODE_RIGHT  = 4'b0010;
    localparam t_code CODE_BOTTOM = 4'b0100;
    localparam t_code CODE_TOP    = 4'b1000;
    localparam t_code CODE_INSIDE = 4'b0000;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } t_cfg_reg;

    // Window edges after reset: 10.0 and 300.0 in the coordinate format.
    localparam t_coord RST_LEFT   = t_coord'(10 << FRACTION_BITS);
    localparam t_coord RST_RIGHT  = t_coord'(300 << FRACTION_BITS);
    localparam t_coord RST_BOTTOM = t_coord'(10 << FRACTION_BITS);
    localparam t_coord RST_TOP    = t_coord'(300 << FRACTION_BITS);

    localparam t_coord COORD_MAX = t_coord'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam t_coord COORD_MIN = t_coord'(-(64'sd1 <<< (COORD_BITS - 1)));
    localparam t_sum   SUM_MAX   = t_sum'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam t_sum   SUM_MIN   = t_sum'(-(64'sd1 <<< (COORD_BITS - 1)));

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord bottom;
        t_coord top;
    } t_window;

    typedef struct packed {
        logic  start;
        t_prod dividend;
        t_mag  divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_prod quotient;
    } t_div_rsp;

    function automatic t_mag mag(input t_diff d);
        t_diff n;
        n = -d;
        return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/clp_outcode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clp_outcode
    import clp_pkg::*;
(
    input  wire t_window i_win,
    input  wire t_coord  i_x,
    input  wire t_coord  i_y,
    output t_code        o_code
);

    always_comb begin
        o_code = CODE_INSIDE;
        if (i_x < i_win.left) begin
            o_code = o_code | CODE_LEFT;
        end else if (i_x > i_win.right) begin
            o_code = o_code | CODE_RIGHT;
        end
        if (i_y < i_win.bottom) begin
            o_code = o_code | CODE_BOTTOM;
        end else if (i_y > i_win.top) begin
            o_code = o_code | CODE_TOP;
        end
    end

endmodule

`default_nettype wire

@@ design/clp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clp_div
    import clp_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      t_div_req i_req,
    output t_div_rsp o_rsp
);

    // Restoring division, one quotient bit per cycle.
    logic                    r_busy;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    t_prod                   r_quo;
    t_mag                    r_rem;
    t_mag                    r_div;

    logic [COORD_BITS:0]     w_shift;
    logic [COORD_BITS:0]     w_trial;
    logic                    w_bit;
    t_mag                    w_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[PROD_BITS-1]};
        w_trial = w_shift - {1'b0, r_div};
        w_bit   = ~w_trial[COORD_BITS];
        w_rem   = w_bit ? w_trial[COORD_BITS-1:0] : w_shift[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_BITS'(PROD_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_quo <= {r_quo[PROD_BITS-2:0], w_bit};
            r_rem <= w_rem;
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == '0);
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

@@ design/line_segment_window_clipper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Cohen-Sutherland line clipper. Each input beat carries one segment as two
// signed fixed-point endpoints (Q12.4 by default); each output beat carries an
// accept flag and the clipped endpoints, which are all zero when the segment
// is rejected. The window comes from four registers written through the
// config port (index 0 left, 1 right, 2 bottom, 3 top) and must only be
// written while the block is idle. The block works on one segment at a time
// and holds o_in_stall high until it has handed the result to its output
// register. Every endpoint move that needs a division uses the shared
// bit-serial divider (one quotient bit per cycle over the 32-bit product),
// and at most 8 moves are made before the segment is rejected. The output
// register lets the next segment be taken while a result still waits
// downstream.
module line_segment_window_clipper
    import clp_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    input  wire                  i_cfg_we,
    input  wire [1:0]            i_cfg_index,
    input  wire [COORD_BITS-1:0] i_cfg_data,

    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire t_coord          i_start_x,
    input  wire t_coord          i_start_y,
    input  wire t_coord          i_end_x,
    input  wire t_coord          i_end_y,

    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_accepted,
    output t_coord               o_clip_start_x,
    output t_coord               o_clip_start_y,
    output t_coord               o_clip_end_x,
    output t_coord               o_clip_end_y
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TEST  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Window registers.
    t_window r_win;

    // Working endpoints and the pass count of the current segment.
    t_coord               r_x1, r_y1, r_x2, r_y2;
    logic [PASS_BITS-1:0] r_pass;
    logic                 r_accept;

    // Operands of the current endpoint move.
    t_coord r_a1;
    t_coord r_edge;
    t_diff  r_da, r_dn, r_dd;
    logic   r_horiz;
    logic   r_first;
    logic   r_neg;
    t_coord r_res;

    // Output register.
    logic   r_out_valid;
    logic   r_out_accepted;
    t_coord r_out_x1, r_out_y1, r_out_x2, r_out_y2;

    t_code    w_c1, w_c2, w_co;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     w_out_free;
    t_sum     w_q_ext;
    t_sum     w_sum;
    t_coord   w_sat;

    // Horizontal-edge or vertical-edge operand selection for the test state.
    t_coord w_a1, w_a2, w_b1, w_b2, w_edge;
    logic   w_horiz;

    clp_outcode u_code1 (
        .i_win  (r_win),
        .i_x    (r_x1),
        .i_y    (r_y1),
        .o_code (w_c1)
    );

    clp_outcode u_code2 (
        .i_win  (r_win),
        .i_x    (r_x2),
        .i_y    (r_y2),
        .o_code (w_c2)
    );

    clp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Configuration writes; a two-bit index always names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= RST_LEFT;
            r_win.right  <= RST_RIGHT;
            r_win.bottom <= RST_BOTTOM;
            r_win.top    <= RST_TOP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_LEFT:   r_win.left   <= i_cfg_data;
                REG_RIGHT:  r_win.right  <= i_cfg_data;
                REG_BOTTOM: r_win.bottom <= i_cfg_data;
                REG_TOP:    r_win.top    <= i_cfg_data;
                default:    r_win        <= r_win;
            endcase
        end
    end

    // The endpoint to move is the first one that lies outside; its edge is
    // chosen in the order top, bottom, right, left.
    always_comb begin
        w_co    = (w_c1 != CODE_INSIDE) ? w_c1 : w_c2;
        w_horiz = |(w_co & (CODE_TOP | CODE_BOTTOM));
        if (w_horiz) begin
            w_a1   = r_x1;
            w_a2   = r_x2;
            w_b1   = r_y1;
            w_b2   = r_y2;
            w_edge = (|(w_co & CODE_TOP)) ? r_win.top : r_win.bottom;
        end else begin
            w_a1   = r_y1;
            w_a2   = r_y2;
            w_b1   = r_x1;
            w_b2   = r_x2;
            w_edge = (|(w_co & CODE_RIGHT)) ? r_win.right : r_win.left;
        end
    end

    // The multiplier feeds the divider's dividend register directly.
    always_comb begin
        w_div_req.start    = (r_state == S_MUL) && (r_dd != '0);
        w_div_req.dividend = t_prod'(mag(r_da)) * t_prod'(mag(r_dn));
        w_div_req.divisor  = mag(r_dd);
    end

    // Apply the sign to the truncated quotient, add the start coordinate and
    // saturate to the coordinate range.
    always_comb begin
        w_q_ext = t_sum'({2'b00, w_div_rsp.quotient});
        w_sum   = t_sum'(r_a1) + (r_neg ? -w_q_ext : w_q_ext);
        if (w_sum > SUM_MAX) begin
            w_sat = COORD_MAX;
        end else if (w_sum < SUM_MIN) begin
            w_sat = COORD_MIN;
        end else begin
            w_sat = w_sum[COORD_BITS-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if ((w_c1 == CODE_INSIDE) && (w_c2 == CODE_INSIDE)) begin
                    n_state = S_DONE;
                end else if ((w_c1 & w_c2) != CODE_INSIDE) begin
                    n_state = S_DONE;
                end else if (r_pass == PASS_BITS'(CLIP_PASS_LIMIT)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = (r_dd == '0) ? S_WRITE : S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_TEST;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x1     <= i_start_x;
                r_y1     <= i_start_y;
                r_x2     <= i_end_x;
                r_y2     <= i_end_y;
                r_pass   <= '0;
                r_accept <= 1'b0;
            end
            S_TEST: begin
                r_accept <= (w_c1 == CODE_INSIDE) && (w_c2 == CODE_INSIDE);
                r_first  <= (w_c1 != CODE_INSIDE);
                r_horiz  <= w_horiz;
                r_a1     <= w_a1;
                r_edge   <= w_edge;
                r_da     <= t_diff'(w_a2) - t_diff'(w_a1);
                r_dn     <= t_diff'(w_edge) - t_diff'(w_b1);
                r_dd     <= t_diff'(w_b2) - t_diff'(w_b1);
            end
            S_MUL: begin
                r_neg <= ((r_da[COORD_BITS] != r_dn[COORD_BITS]) != r_dd[COORD_BITS]);
                r_res <= r_a1;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_res <= w_sat;
                end
            end
            S_WRITE: begin
                r_pass <= r_pass + 1'b1;
                if (r_first) begin
                    r_x1 <= r_horiz ? r_res : r_edge;
                    r_y1 <= r_horiz ? r_edge : r_res;
                end else begin
                    r_x2 <= r_horiz ? r_res : r_edge;
                    r_y2 <= r_horiz ? r_edge : r_res;
                end
            end
            S_DONE: begin
                r_pass <= r_pass;
            end
            default: begin
                r_pass <= r_pass;
            end
        endcase
    end

    // Output register: loaded when the sequencer finishes and the register
    // is empty or being emptied in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_accepted <= r_accept;
            r_out_x1       <= r_accept ? r_x1 : '0;
            r_out_y1       <= r_accept ? r_y1 : '0;
            r_out_x2       <= r_accept ? r_x2 : '0;
            r_out_y2       <= r_accept ? r_y2 : '0;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_accepted;
    assign o_clip_start_x = r_out_x1;
    assign o_clip_start_y = r_out_y1;
    assign o_clip_end_x   = r_out_x2;
    assign o_clip_end_y   = r_out_y2;

endmodule

`default_nettype wire

@@ design/clp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clp_checker
    import clp_pkg::*;
(
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_in_valid,
    input wire         i_in_stall,
    input wire         i_out_valid,
    input wire         i_out_stall,
    input wire         i_accepted,
    input wire t_coord i_clip_start_x,
    input wire t_coord i_clip_start_y,
    input wire t_coord i_clip_end_x,
    input wire t_coord i_clip_end_y
);

    // A segment keeps the block busy for at least the cycle after its beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("input not stalled after a segment was taken");

    // A new result only appears while a segment was being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared without a segment in progress");

    // A rejected segment reports all coordinates as zero.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_accepted) |->
            (i_clip_start_x == '0) && (i_clip_start_y == '0) &&
            (i_clip_end_x == '0) && (i_clip_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=>
            (i_out_valid && $stable(i_accepted) && $stable(i_clip_start_x) &&
             $stable(i_clip_start_y) && $stable(i_clip_end_x) &&
             $stable(i_clip_end_y)))
        else $error("stalled result beat changed");

endmodule

bind line_segment_window_clipper clp_checker u_clp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_stall     (o_in_stall),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_accepted     (o_accepted),
    .i_clip_start_x (o_clip_start_x),
    .i_clip_start_y (o_clip_start_y),
    .i_clip_end_x   (o_clip_end_x),
    .i_clip_end_y   (o_clip_end_y)
);

`default_nettype wire
